// ===== design/rbsi_pkg.sv =====
// Shared types, constants and helpers for the ray/box slab intersection block.
// Used by every module under design/ except rbsi_div; depends on nothing.
`default_nettype none

package rbsi_pkg;

  // Fixed-point format of coordinates and distances
  localparam int COORD_W  = 32;
  localparam int FRAC_W   = 16;
  localparam int THRESH_W = 31;
  // Scaled dividend: (corner - origin) << FRAC_W
  localparam int NUM_W    = COORD_W + 1 + FRAC_W;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Z  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd6;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Input word: one ray
  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
  } ray_t;

  // Output word: hit flag and entry point
  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } result_t;

  // What one axis lane hands to the merge stage
  typedef struct packed {
    logic                      par;
    logic                      pmiss;
    logic signed [COORD_W-1:0] t0;
    logic signed [COORD_W-1:0] t1;
    logic signed [COORD_W-1:0] org;
    logic signed [COORD_W-1:0] dir;
  } lane_res_t;

  // Saturate a sign/magnitude quotient to a coordinate
  function automatic logic signed [COORD_W-1:0] sat_quot(input logic neg,
                                                         input logic [NUM_W-1:0] mag);
    logic [NUM_W-1:0] pos_lim;
    logic [NUM_W-1:0] neg_lim;
    logic [NUM_W-1:0] negv;
    logic signed [COORD_W-1:0] r;
    pos_lim = {{(NUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    neg_lim = {{(NUM_W-COORD_W){1'b0}}, 1'b1, {(COORD_W-1){1'b0}}};
    negv    = ~mag + 1'b1;
    if (!neg) begin
      r = (mag > pos_lim) ? COORD_MAX : mag[COORD_W-1:0];
    end else begin
      r = (mag > neg_lim) ? COORD_MIN : negv[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/ray_box_slab_intersection.sv =====
// Ray versus axis-aligned box, slab method, Q16.16. From input accept to output
// valid a ray passes the prep stage, the 50-stage divider pipeline in each lane
// (operand stage plus one quotient bit per stage), the sort stage, three merge
// stages and the output register. Throughput is one ray per cycle; a stalled
// output word freezes the whole pipe. Synchronous reset clears the valid
// pipeline and loads the empty box with a parallel threshold of 1. Depends on
// rbsi_pkg, rbsi_lane and rbsi_merge.
`default_nettype none

module ray_box_slab_intersection (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire rbsi_pkg::ray_t                     in_word,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output rbsi_pkg::result_t                       out_word,
  input  wire logic                               cfg_we,
  input  wire logic [rbsi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rbsi_pkg::COORD_W-1:0]       cfg_data
);

  localparam int CW = rbsi_pkg::COORD_W;
  localparam int VN = rbsi_pkg::NUM_W + 6;  // stages ahead of the output register

  // Configuration registers
  logic signed [CW-1:0]                box_min [0:2];
  logic signed [CW-1:0]                box_max [0:2];
  logic        [rbsi_pkg::THRESH_W-1:0] thresh;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        box_min[a] <= rbsi_pkg::COORD_MAX;
        box_max[a] <= rbsi_pkg::COORD_MIN;
      end
      thresh <= {{(rbsi_pkg::THRESH_W-1){1'b0}}, 1'b1};
    end else if (cfg_we) begin
      case (cfg_index)
        rbsi_pkg::REG_MIN_X:  box_min[0] <= cfg_data;
        rbsi_pkg::REG_MIN_Y:  box_min[1] <= cfg_data;
        rbsi_pkg::REG_MIN_Z:  box_min[2] <= cfg_data;
        rbsi_pkg::REG_MAX_X:  box_max[0] <= cfg_data;
        rbsi_pkg::REG_MAX_Y:  box_max[1] <= cfg_data;
        rbsi_pkg::REG_MAX_Z:  box_max[2] <= cfg_data;
        rbsi_pkg::REG_THRESH: thresh     <= cfg_data[rbsi_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipe advances unless a finished word is held by the sink
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic [VN-1:0] vpipe;
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe     <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vpipe     <= {vpipe[VN-2:0], in_valid};
      out_valid <= vpipe[VN-1];
    end
  end

  // Three axis lanes
  rbsi_pkg::lane_res_t lane_r [0:2];
  logic signed [CW-1:0] org_in [0:2];
  logic signed [CW-1:0] dir_in [0:2];

  assign org_in[0] = in_word.origin_x;
  assign org_in[1] = in_word.origin_y;
  assign org_in[2] = in_word.origin_z;
  assign dir_in[0] = in_word.dir_x;
  assign dir_in[1] = in_word.dir_y;
  assign dir_in[2] = in_word.dir_z;

  for (genvar a = 0; a < 3; a++) begin : g_lane
    rbsi_lane u_lane (
      .clk (clk),
      .en  (en),
      .org (org_in[a]),
      .dir (dir_in[a]),
      .lo  (box_min[a]),
      .hi  (box_max[a]),
      .thr (thresh),
      .res (lane_r[a])
    );
  end

  rbsi_pkg::result_t merged;

  rbsi_merge u_merge (
    .clk    (clk),
    .en     (en),
    .lane_x (lane_r[0]),
    .lane_y (lane_r[1]),
    .lane_z (lane_r[2]),
    .result (merged)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= merged;
    end
  end

  // A miss carries a zero point
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.hit |->
      (out_word.point_x == '0) && (out_word.point_y == '0) && (out_word.point_z == '0))
    else $error("miss word with nonzero point");

  // No word comes out right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // A word at the pipe end reaches the output when the pipe moves
  a_pipe_end: assert property (@(posedge clk) disable iff (rst)
    en && vpipe[VN-1] |=> out_valid)
    else $error("word lost at pipe end");

  // Input is held off only while a word waits at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && $past(vpipe[VN-1] || out_valid))
    else $error("input stalled without a pending output");

endmodule

`default_nettype wire

// ===== design/rbsi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, signed operands.
// Quotient truncates toward zero; returned as sign and magnitude. Uses no package.
`default_nettype none

module rbsi_div #(
  parameter int NW = 49,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [NW-1:0] q_mag,
  output logic               q_neg
);

  logic [NW-1:0] num_s [0:NW];
  logic [DW-1:0] rem_s [0:NW];
  logic [DW-1:0] den_s [0:NW];
  logic          neg_s [0:NW];

  // Stage 0: magnitudes and quotient sign
  always_ff @(posedge clk) begin
    if (en) begin
      num_s[0] <= num[NW-1] ? (~num + 1'b1) : num;
      den_s[0] <= den[DW-1] ? (~den + 1'b1) : den;
      rem_s[0] <= '0;
      neg_s[0] <= num[NW-1] ^ den[DW-1];
    end
  end

  // One quotient bit per stage; quotient bits shift in at the bottom
  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] sub;
    logic        ge;
    assign trial = {rem_s[k], num_s[k][NW-1]};
    assign sub   = trial - {1'b0, den_s[k]};
    assign ge    = trial >= {1'b0, den_s[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= ge ? sub[DW-1:0] : trial[DW-1:0];
        num_s[k+1] <= {num_s[k][NW-2:0], ge};
        den_s[k+1] <= den_s[k];
        neg_s[k+1] <= neg_s[k];
      end
    end
  end

  assign q_mag = num_s[NW];
  assign q_neg = neg_s[NW];

endmodule

`default_nettype wire

// ===== design/rbsi_lane.sv =====
// One axis lane: parallel test, two pipelined slab divisions, saturate and sort.
// Depends on rbsi_pkg and rbsi_div.
`default_nettype none

module rbsi_lane (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic signed [rbsi_pkg::COORD_W-1:0] org,
  input  wire logic signed [rbsi_pkg::COORD_W-1:0] dir,
  input  wire logic signed [rbsi_pkg::COORD_W-1:0] lo,
  input  wire logic signed [rbsi_pkg::COORD_W-1:0] hi,
  input  wire logic        [rbsi_pkg::THRESH_W-1:0] thr,
  output rbsi_pkg::lane_res_t                     res
);

  localparam int CW = rbsi_pkg::COORD_W;
  localparam int NW = rbsi_pkg::NUM_W;
  localparam int DL = NW + 1;  // divider latency

  logic signed [CW:0]   diff_lo;
  logic signed [CW:0]   diff_hi;
  logic signed [CW-1:0] org_p;
  logic signed [CW-1:0] dir_p;
  logic                 par_p;
  logic                 pmiss_p;

  logic signed [CW:0] dir_ext;
  logic        [CW:0] mag;
  logic               par;

  // Parallel axis test
  assign dir_ext = {dir[CW-1], dir};
  assign mag     = dir[CW-1] ? $unsigned(-dir_ext) : $unsigned(dir_ext);
  assign par     = (dir == '0) ||
                   (mag < {{(CW+1-rbsi_pkg::THRESH_W){1'b0}}, thr});

  // Prep stage: slab offsets and flags
  always_ff @(posedge clk) begin
    if (en) begin
      diff_lo <= {lo[CW-1], lo} - {org[CW-1], org};
      diff_hi <= {hi[CW-1], hi} - {org[CW-1], org};
      org_p   <= org;
      dir_p   <= dir;
      par_p   <= par;
      pmiss_p <= par && ((org < lo) || (org > hi));
    end
  end

  logic [NW-1:0] q0_mag;
  logic [NW-1:0] q1_mag;
  logic          q0_neg;
  logic          q1_neg;

  rbsi_div #(.NW(NW), .DW(CW)) u_div_lo (
    .clk   (clk),
    .en    (en),
    .num   ({diff_lo, {rbsi_pkg::FRAC_W{1'b0}}}),
    .den   (dir_p),
    .q_mag (q0_mag),
    .q_neg (q0_neg)
  );

  rbsi_div #(.NW(NW), .DW(CW)) u_div_hi (
    .clk   (clk),
    .en    (en),
    .num   ({diff_hi, {rbsi_pkg::FRAC_W{1'b0}}}),
    .den   (dir_p),
    .q_mag (q1_mag),
    .q_neg (q1_neg)
  );

  // Side data delayed to match the dividers
  logic signed [CW-1:0] org_d [0:DL-1];
  logic signed [CW-1:0] dir_d [0:DL-1];
  logic                 par_d [0:DL-1];
  logic                 pm_d  [0:DL-1];

  always_ff @(posedge clk) begin
    if (en) begin
      org_d[0] <= org_p;
      dir_d[0] <= dir_p;
      par_d[0] <= par_p;
      pm_d[0]  <= pmiss_p;
      for (int i = 1; i < DL; i++) begin
        org_d[i] <= org_d[i-1];
        dir_d[i] <= dir_d[i-1];
        par_d[i] <= par_d[i-1];
        pm_d[i]  <= pm_d[i-1];
      end
    end
  end

  logic signed [CW-1:0] t0;
  logic signed [CW-1:0] t1;
  assign t0 = rbsi_pkg::sat_quot(q0_neg, q0_mag);
  assign t1 = rbsi_pkg::sat_quot(q1_neg, q1_mag);

  // Post stage: order the slab distances
  always_ff @(posedge clk) begin
    if (en) begin
      res.t0    <= (t0 > t1) ? t1 : t0;
      res.t1    <= (t0 > t1) ? t0 : t1;
      res.org   <= org_d[DL-1];
      res.dir   <= dir_d[DL-1];
      res.par   <= par_d[DL-1];
      res.pmiss <= pm_d[DL-1];
    end
  end

endmodule

`default_nettype wire

// ===== design/rbsi_merge.sv =====
// Merge stage: combines the three lane intervals and forms the entry point.
// Depends on rbsi_pkg. Three register stages; the final sum is combinational.
`default_nettype none

module rbsi_merge (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire rbsi_pkg::lane_res_t lane_x,
  input  wire rbsi_pkg::lane_res_t lane_y,
  input  wire rbsi_pkg::lane_res_t lane_z,
  output rbsi_pkg::result_t        result
);

  localparam int CW = rbsi_pkg::COORD_W;
  localparam int F  = rbsi_pkg::FRAC_W;
  localparam int PW = 2 * CW;
  localparam int SW = PW - F + 1;
  localparam logic signed [SW-1:0] PMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] PMIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  // Stage 1: x then y
  logic signed [CW-1:0] ent_x;
  logic signed [CW-1:0] ext_x;
  logic                 miss_y;

  assign ent_x  = lane_x.par ? '0 : lane_x.t0;
  assign ext_x  = lane_x.par ? rbsi_pkg::COORD_MAX : lane_x.t1;
  assign miss_y = lane_x.pmiss || lane_y.pmiss ||
                  (!lane_y.par && ((ent_x > lane_y.t1) || (lane_y.t0 > ext_x)));

  logic signed [CW-1:0] ent1;
  logic signed [CW-1:0] ext1;
  logic                 miss1;
  rbsi_pkg::lane_res_t  z1;
  logic signed [CW-1:0] org1 [0:1];
  logic signed [CW-1:0] dir1 [0:1];

  always_ff @(posedge clk) begin
    if (en) begin
      ent1    <= (!lane_y.par && (lane_y.t0 > ent_x)) ? lane_y.t0 : ent_x;
      ext1    <= (!lane_y.par && (lane_y.t1 < ext_x)) ? lane_y.t1 : ext_x;
      miss1   <= miss_y;
      z1      <= lane_z;
      org1[0] <= lane_x.org;
      org1[1] <= lane_y.org;
      dir1[0] <= lane_x.dir;
      dir1[1] <= lane_y.dir;
    end
  end

  // Stage 2: z
  logic                 miss_z;
  logic signed [CW-1:0] ent2;
  logic                 miss2;
  logic signed [CW-1:0] org2 [0:2];
  logic signed [CW-1:0] dir2 [0:2];

  assign miss_z = miss1 || z1.pmiss ||
                  (!z1.par && ((ent1 > z1.t1) || (z1.t0 > ext1)));

  always_ff @(posedge clk) begin
    if (en) begin
      ent2    <= (!z1.par && (z1.t0 > ent1)) ? z1.t0 : ent1;
      miss2   <= miss_z;
      org2[0] <= org1[0];
      org2[1] <= org1[1];
      org2[2] <= z1.org;
      dir2[0] <= dir1[0];
      dir2[1] <= dir1[1];
      dir2[2] <= z1.dir;
    end
  end

  // Stage 3: direction times entry distance, one multiplier per axis
  logic signed [PW-1:0] prod3 [0:2];
  logic signed [CW-1:0] org3  [0:2];
  logic                 miss3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        prod3[a] <= dir2[a] * ent2;
        org3[a]  <= org2[a];
      end
      miss3 <= miss2;
    end
  end

  // Floor shift, add origin, saturate
  logic signed [CW-1:0] pt [0:2];
  for (genvar a = 0; a < 3; a++) begin : g_pt
    logic signed [SW-1:0] sum;
    assign sum = {prod3[a][PW-1], prod3[a][PW-1:F]} +
                 {{(SW-CW){org3[a][CW-1]}}, org3[a]};
    assign pt[a] = (sum > PMAX) ? rbsi_pkg::COORD_MAX :
                   (sum < PMIN) ? rbsi_pkg::COORD_MIN : sum[CW-1:0];
  end

  assign result.hit     = !miss3;
  assign result.point_x = miss3 ? '0 : pt[0];
  assign result.point_y = miss3 ? '0 : pt[1];
  assign result.point_z = miss3 ? '0 : pt[2];

endmodule

`default_nettype wire
